### hw/rtl/dpt_pkg.sv
package dpt_pkg;

  // Default number of lease slots.
  localparam int unsigned TableDepthDefault = 64;

  // Location codes.
  localparam logic [1:0] PlacePool0 = 2'd0;
  localparam logic [1:0] PlacePool1 = 2'd1;
  localparam logic [1:0] PlaceHost  = 2'd2;

  // Action codes.
  localparam logic [2:0] ActPlace    = 3'd0;
  localparam logic [2:0] ActRedirect = 3'd1;
  localparam logic [2:0] ActRebal    = 3'd2;
  localparam logic [2:0] ActFault    = 3'd3;
  localparam logic [2:0] ActFail     = 3'd4;
  localparam logic [2:0] ActQuery    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CfgBudget0   = 2'd0;
  localparam logic [1:0] CfgBudget1   = 2'd1;
  localparam logic [1:0] CfgThreshold = 2'd2;
  localparam logic [1:0] CfgEnabled   = 2'd3;

  // Q1.16 utilisation constants.
  localparam logic [16:0] UtilOne = 17'h10000;
  localparam logic [16:0] UtilMax = 17'h1FFFF;
  localparam logic [16:0] ThresholdReset = 17'd6554;

  // One entry of the lease table.
  typedef struct packed {
    logic [31:0] tag;
    logic [47:0] nbytes;
    logic [1:0]  place;
    logic [31:0] lease;
  } slot_t;

  // Byte usage counters.
  typedef struct packed {
    logic [47:0] p0;
    logic [47:0] p1;
    logic [47:0] host;
  } usage_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [47:0] used;
    logic [47:0] budget;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

  // One result item.
  typedef struct packed {
    logic        ok;
    logic [31:0] lease;
    logic [1:0]  now;
    logic [1:0]  prior;
    logic [47:0] moved;
    logic        oom;
    logic [47:0] p0;
    logic [47:0] p1;
    logic [47:0] host;
    logic [6:0]  count;
    logic        balanced;
  } result_t;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic logic [47:0] sat_sub(logic [47:0] a, logic [47:0] b);
    return (a > b) ? (a - b) : 48'd0;
  endfunction

  // A block fits when used plus bytes stays within the budget.
  function automatic logic fits(logic [47:0] used, logic [47:0] b, logic [47:0] budget);
    return ({1'b0, used} + {1'b0, b}) <= {1'b0, budget};
  endfunction

  function automatic logic [47:0] used_of(usage_t u, logic [1:0] p);
    logic [47:0] r;
    case (p)
      PlacePool0: r = u.p0;
      PlacePool1: r = u.p1;
      default:    r = u.host;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] budget_of(logic [1:0] p, logic [47:0] b0, logic [47:0] b1);
    logic [47:0] r;
    case (p)
      PlacePool0: r = b0;
      PlacePool1: r = b1;
      default:    r = 48'd0;
    endcase
    return r;
  endfunction

  function automatic usage_t usage_sub(usage_t u, logic [1:0] p, logic [47:0] b);
    usage_t r;
    r = u;
    case (p)
      PlacePool0: r.p0 = sat_sub(u.p0, b);
      PlacePool1: r.p1 = sat_sub(u.p1, b);
      default:    r.host = sat_sub(u.host, b);
    endcase
    return r;
  endfunction

  function automatic usage_t usage_add(usage_t u, logic [1:0] p, logic [47:0] b);
    usage_t r;
    r = u;
    case (p)
      PlacePool0: r.p0 = sat_add(u.p0, b);
      PlacePool1: r.p1 = sat_add(u.p1, b);
      default:    r.host = sat_add(u.host, b);
    endcase
    return r;
  endfunction

  // Release the bytes at the source, then account them at the destination.
  function automatic usage_t usage_move(usage_t u, logic [1:0] src, logic [1:0] dst,
                                        logic [47:0] b);
    return usage_add(usage_sub(u, src, b), dst, b);
  endfunction

endpackage

### hw/rtl/dpt_slot_mem.sv
module dpt_slot_mem #(
  parameter int unsigned Depth = dpt_pkg::TableDepthDefault
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  dpt_pkg::slot_t           wdata_i,
  output dpt_pkg::slot_t           rdata_o
);

  dpt_pkg::slot_t mem_q [Depth];
  dpt_pkg::slot_t rdata_q;

  // Single port: optional write and registered read of the addressed entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dpt_util_div.sv
module dpt_util_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpt_pkg::div_req_t req_i,
  output dpt_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  step_q, step_d;
  logic [47:0] rem_q, rem_d;
  logic [47:0] bud_q, bud_d;
  logic        lsb_q, lsb_d;
  logic [16:0] quot_q, quot_d;
  logic [48:0] trial;
  logic        ge;
  logic [48:0] diff;

  // One quotient bit per cycle; only bit sixteen of the dividend is non-zero below.
  always_comb begin
    trial = {rem_q, (step_q == 5'd16) ? lsb_q : 1'b0};
    ge    = trial >= {1'b0, bud_q};
    diff  = ge ? (trial - {1'b0, bud_q}) : trial;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    bud_d  = bud_q;
    lsb_d  = lsb_q;
    quot_d = quot_q;
    if (req_i.start) begin
      // A quotient of two or more saturates at once.
      if ({1'b0, req_i.used} >= {req_i.budget, 1'b0}) begin
        quot_d = dpt_pkg::UtilMax;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = {1'b0, req_i.used[47:1]};
        lsb_d  = req_i.used[0];
        bud_d  = req_i.budget;
        step_d = 5'd16;
        quot_d = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      quot_d = {quot_q[15:0], ge};
      rem_d  = diff[47:0];
      if (step_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      bud_q  <= '0;
      lsb_q  <= 1'b0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      bud_q  <= bud_d;
      lsb_q  <= lsb_d;
      quot_q <= quot_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### hw/rtl/dual_pool_tensor_placement_unit.sv
// Lease table that places tensor blocks on one of two byte-budgeted pools or the host.
// Input channel (in_valid_i / in_ready_o) carries one action per transfer; output
// channel (out_valid_o / out_ready_i) returns exactly one result per action.
// Configuration writes use cfg_valid_i / cfg_ready_o with a register index and data,
// and are always taken; they must only be issued while the block is idle.
// Flow: an action that walks the table spends a memory-read step and an evaluate step
// per slot visited, because the lease table sits in a single-port memory with a
// registered read. Every action then computes both pool utilisations on a shared
// divider (a saturating quotient finishes early), then one closing step and one step
// to load the output register; a placement that writes a slot and a rebalance with a
// non-zero budget use the divider once more before acting. One action is in flight
// at a time.
// The output register holds the result until it is taken; a stalled receiver holds
// the block at its final step but a new action is accepted once the result is queued.
// Reset clears all slot valid bits, the usage counters and the lease counter (to one);
// budgets reset to zero, the threshold to 6554 and placement is enabled.
module dual_pool_tensor_placement_unit #(
  parameter int unsigned TABLE_DEPTH = dpt_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] tensor_tag_i,
  input  logic [47:0] byte_count_i,
  input  logic [1:0]  target_place_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [31:0] lease_number_o,
  output logic [1:0]  where_now_o,
  output logic [1:0]  where_before_o,
  output logic [47:0] bytes_moved_o,
  output logic        out_of_memory_o,
  output logic [47:0] pool0_bytes_o,
  output logic [47:0] pool1_bytes_o,
  output logic [47:0] host_bytes_o,
  output logic [6:0]  lease_count_o,
  output logic        balanced_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EV    = 4'd2;
  localparam logic [3:0] S_ACT   = 4'd3;
  localparam logic [3:0] S_U0    = 4'd4;
  localparam logic [3:0] S_U0W   = 4'd5;
  localparam logic [3:0] S_U1    = 4'd6;
  localparam logic [3:0] S_U1W   = 4'd7;
  localparam logic [3:0] S_UDONE = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [1:0] PH_PLACE = 2'd0;
  localparam logic [1:0] PH_REBAL = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [3:0]        state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [47:0]       bud0_q, bud0_d, bud1_q, bud1_d;
  logic [16:0]       thr_q, thr_d;
  logic              en_q, en_d;
  logic [2:0]        act_q, act_d;
  logic [31:0]       tag_q, tag_d;
  logic [47:0]       bytes_q, bytes_d;
  logic [1:0]        tgt_q, tgt_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              hit_q, hit_d, free_q, free_d;
  logic [IW-1:0]     hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  dpt_pkg::slot_t    sd_q, sd_d;
  dpt_pkg::usage_t   use_q, use_d;
  logic [31:0]       next_q, next_d;
  logic [CW-1:0]     count_q, count_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [1:0]        src_q, src_d;
  logic [16:0]       u0_q, u0_d, u1_q, u1_d;
  dpt_pkg::result_t  res_q, res_d;
  dpt_pkg::result_t  out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_addr;
  dpt_pkg::slot_t    mem_wdata, mem_rdata;
  dpt_pkg::div_req_t div_req;
  dpt_pkg::div_rsp_t div_rsp;

  logic [16:0]       zero_val, ua, ub, udiff;
  logic [1:0]        dst, to, pick;
  logic              f0, f1, vhere, last;
  logic [IW-1:0]     slot_at;
  logic [31:0]       count32;

  dpt_slot_mem #(
    .Depth(TABLE_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .addr_i (mem_addr),
    .we_i   (mem_we),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  dpt_util_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Divider requests: pool zero first, then pool one.
  always_comb begin
    div_req.start  = (state_q == S_U0) || (state_q == S_U1);
    div_req.used   = (state_q == S_U0) ? use_q.p0 : use_q.p1;
    div_req.budget = (state_q == S_U0) ? bud0_q : bud1_q;
  end

  // Utilisations with the zero-budget value of the current phase.
  always_comb begin
    zero_val = (phase_q == PH_FINAL) ? 17'd0 : dpt_pkg::UtilOne;
    ua       = (bud0_q == 48'd0) ? zero_val : u0_q;
    ub       = (bud1_q == 48'd0) ? zero_val : u1_q;
    udiff    = (ua > ub) ? (ua - ub) : (ub - ua);
  end

  assign mem_addr = mem_we ? mem_waddr : idx_q;
  assign vhere    = valid_q[idx_q];
  assign last     = (idx_q == LastIdx);
  assign count32  = 32'(count_q);

  // Main sequencer.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    bud0_d      = bud0_q;
    bud1_d      = bud1_q;
    thr_d       = thr_q;
    en_d        = en_q;
    act_d       = act_q;
    tag_d       = tag_q;
    bytes_d     = bytes_q;
    tgt_d       = tgt_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    free_d      = free_q;
    hit_idx_d   = hit_idx_q;
    free_idx_d  = free_idx_q;
    sd_d        = sd_q;
    use_d       = use_q;
    next_d      = next_q;
    count_d     = count_q;
    valid_d     = valid_q;
    src_d       = src_q;
    u0_d        = u0_q;
    u1_d        = u1_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = mem_rdata;
    dst         = dpt_pkg::PlacePool0;
    to          = dpt_pkg::PlaceHost;
    pick        = dpt_pkg::PlaceHost;
    f0          = 1'b0;
    f1          = 1'b0;
    slot_at     = hit_q ? hit_idx_q : free_idx_q;

    // Configuration writes.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dpt_pkg::CfgBudget0:   bud0_d = cfg_data_i;
        dpt_pkg::CfgBudget1:   bud1_d = cfg_data_i;
        dpt_pkg::CfgThreshold: thr_d  = cfg_data_i[16:0];
        dpt_pkg::CfgEnabled:   en_d   = cfg_data_i[0];
        default:               en_d   = en_q;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          tag_d   = tensor_tag_i;
          bytes_d = byte_count_i;
          tgt_d   = target_place_i;
          res_d   = '0;
          idx_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          phase_d = PH_FINAL;
          state_d = S_U0;
          case (action_i) inside
            dpt_pkg::ActPlace: begin
              if (en_q && (byte_count_i != 48'd0)) state_d = S_RD;
            end
            dpt_pkg::ActRedirect, dpt_pkg::ActFault, dpt_pkg::ActQuery: state_d = S_RD;
            dpt_pkg::ActRebal: begin
              if ((bud0_q != 48'd0) || (bud1_q != 48'd0)) phase_d = PH_REBAL;
            end
            dpt_pkg::ActFail: begin
              if (target_place_i <= dpt_pkg::PlacePool1) state_d = S_RD;
            end
            default: state_d = S_U0;
          endcase
        end
      end

      S_RD: state_d = S_EV;

      // Evaluate one slot of the walk.
      S_EV: begin
        case (act_q)
          dpt_pkg::ActRebal: begin
            dst = (src_q == dpt_pkg::PlacePool0) ? dpt_pkg::PlacePool1 : dpt_pkg::PlacePool0;
            if (vhere && (mem_rdata.place == src_q) &&
                dpt_pkg::fits(dpt_pkg::used_of(use_q, dst), mem_rdata.nbytes,
                              dpt_pkg::budget_of(dst, bud0_q, bud1_q))) begin
              use_d           = dpt_pkg::usage_move(use_q, src_q, dst, mem_rdata.nbytes);
              mem_we          = 1'b1;
              mem_wdata.place = dst;
              res_d.ok        = 1'b1;
              res_d.lease     = mem_rdata.lease;
              res_d.now       = dst;
              phase_d         = PH_FINAL;
              state_d         = S_U0;
            end else if (last) begin
              phase_d = PH_FINAL;
              state_d = S_U0;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_RD;
            end
          end
          dpt_pkg::ActFail: begin
            dst = (tgt_q == dpt_pkg::PlacePool0) ? dpt_pkg::PlacePool1 : dpt_pkg::PlacePool0;
            to  = dpt_pkg::fits(dpt_pkg::used_of(use_q, dst), mem_rdata.nbytes,
                                dpt_pkg::budget_of(dst, bud0_q, bud1_q)) ?
                  dst : dpt_pkg::PlaceHost;
            if (vhere && (mem_rdata.place == tgt_q)) begin
              use_d           = dpt_pkg::usage_move(use_q, tgt_q, to, mem_rdata.nbytes);
              mem_we          = 1'b1;
              mem_wdata.place = to;
              res_d.ok        = 1'b1;
              res_d.lease     = mem_rdata.lease;
              res_d.now       = to;
            end
            if (last) begin
              phase_d = PH_FINAL;
              state_d = S_U0;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_RD;
            end
          end
          default: begin
            // Tag lookup, noting the first free slot on the way.
            if (vhere && (mem_rdata.tag == tag_q)) begin
              hit_d     = 1'b1;
              hit_idx_d = idx_q;
              sd_d      = mem_rdata;
              state_d   = S_ACT;
            end else begin
              if (!vhere && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = idx_q;
              end
              if (last) begin
                state_d = S_ACT;
              end else begin
                idx_d   = idx_q + 1'b1;
                state_d = S_RD;
              end
            end
          end
        endcase
      end

      // Act on the result of a tag lookup.
      S_ACT: begin
        phase_d = PH_FINAL;
        state_d = S_U0;
        mem_waddr = hit_idx_q;
        mem_wdata = sd_q;
        case (act_q)
          dpt_pkg::ActPlace: begin
            if (hit_q && (sd_q.nbytes == bytes_q)) begin
              res_d.ok    = 1'b1;
              res_d.lease = sd_q.lease;
              res_d.now   = sd_q.place;
            end else if (hit_q) begin
              use_d   = dpt_pkg::usage_sub(use_q, sd_q.place, sd_q.nbytes);
              phase_d = PH_PLACE;
            end else if (free_q) begin
              phase_d = PH_PLACE;
            end
          end
          dpt_pkg::ActRedirect: begin
            if (hit_q && (tgt_q <= dpt_pkg::PlaceHost)) begin
              if (sd_q.place == tgt_q) begin
                res_d.ok  = 1'b1;
                res_d.now = tgt_q;
              end else if ((tgt_q == dpt_pkg::PlaceHost) ||
                           dpt_pkg::fits(dpt_pkg::used_of(use_q, tgt_q), sd_q.nbytes,
                                         dpt_pkg::budget_of(tgt_q, bud0_q, bud1_q))) begin
                use_d           = dpt_pkg::usage_move(use_q, sd_q.place, tgt_q, sd_q.nbytes);
                mem_we          = 1'b1;
                mem_wdata.place = tgt_q;
                res_d.ok        = 1'b1;
                res_d.prior     = sd_q.place;
                res_d.lease     = sd_q.lease;
                res_d.now       = tgt_q;
                res_d.moved     = sd_q.nbytes;
              end
            end
          end
          dpt_pkg::ActFault: begin
            if (hit_q) begin
              use_d = dpt_pkg::usage_move(use_q, sd_q.place, dpt_pkg::PlaceHost,
                                          sd_q.nbytes);
              mem_we          = 1'b1;
              mem_wdata.place = dpt_pkg::PlaceHost;
              res_d.ok        = 1'b1;
              res_d.lease     = sd_q.lease;
              res_d.now       = dpt_pkg::PlaceHost;
            end
          end
          dpt_pkg::ActQuery: begin
            if (hit_q) begin
              res_d.ok    = 1'b1;
              res_d.lease = sd_q.lease;
              res_d.now   = sd_q.place;
            end
          end
          default: phase_d = PH_FINAL;
        endcase
      end

      S_U0: state_d = S_U0W;

      S_U0W: begin
        if (div_rsp.done) begin
          u0_d    = div_rsp.quot;
          state_d = S_U1;
        end
      end

      S_U1: state_d = S_U1W;

      S_U1W: begin
        if (div_rsp.done) begin
          u1_d    = div_rsp.quot;
          state_d = S_UDONE;
        end
      end

      S_UDONE: begin
        unique case (phase_q)
          PH_PLACE: begin
            // Choose the fitting pool with the lower utilisation (pool zero on a tie), else the host.
            f0 = dpt_pkg::fits(use_q.p0, bytes_q, bud0_q);
            f1 = dpt_pkg::fits(use_q.p1, bytes_q, bud1_q);
            if (f0 && f1) pick = (ua <= ub) ? dpt_pkg::PlacePool0 : dpt_pkg::PlacePool1;
            else if (f0)  pick = dpt_pkg::PlacePool0;
            else if (f1)  pick = dpt_pkg::PlacePool1;
            else          pick = dpt_pkg::PlaceHost;
            mem_we           = 1'b1;
            mem_waddr        = slot_at;
            mem_wdata.tag    = tag_q;
            mem_wdata.nbytes = bytes_q;
            mem_wdata.place  = pick;
            mem_wdata.lease  = next_q;
            valid_d[slot_at] = 1'b1;
            if (!hit_q) count_d = count_q + 1'b1;
            next_d      = next_q + 32'd1;
            use_d       = dpt_pkg::usage_add(use_q, pick, bytes_q);
            res_d.ok    = 1'b1;
            res_d.lease = next_q;
            res_d.now   = pick;
            res_d.oom   = (pick == dpt_pkg::PlaceHost);
            phase_d     = PH_FINAL;
            state_d     = S_U0;
          end
          PH_REBAL: begin
            phase_d = PH_FINAL;
            if (udiff > thr_q) begin
              src_d   = (ua > ub) ? dpt_pkg::PlacePool0 : dpt_pkg::PlacePool1;
              idx_d   = '0;
              state_d = S_RD;
            end else begin
              state_d = S_U0;
            end
          end
          PH_FINAL: begin
            res_d.balanced = (udiff <= thr_q);
            state_d        = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end

      // Move the result into the output register once it is free.
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_d.p0    = use_q.p0;
          out_d.p1    = use_q.p1;
          out_d.host  = use_q.host;
          out_d.count = count32[6:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FINAL;
      bud0_q      <= '0;
      bud1_q      <= '0;
      thr_q       <= dpt_pkg::ThresholdReset;
      en_q        <= 1'b1;
      act_q       <= '0;
      tag_q       <= '0;
      bytes_q     <= '0;
      tgt_q       <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      hit_idx_q   <= '0;
      free_idx_q  <= '0;
      sd_q        <= '0;
      use_q       <= '0;
      next_q      <= 32'd1;
      count_q     <= '0;
      valid_q     <= '0;
      src_q       <= '0;
      u0_q        <= '0;
      u1_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      bud0_q      <= bud0_d;
      bud1_q      <= bud1_d;
      thr_q       <= thr_d;
      en_q        <= en_d;
      act_q       <= act_d;
      tag_q       <= tag_d;
      bytes_q     <= bytes_d;
      tgt_q       <= tgt_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      hit_idx_q   <= hit_idx_d;
      free_idx_q  <= free_idx_d;
      sd_q        <= sd_d;
      use_q       <= use_d;
      next_q      <= next_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      src_q       <= src_d;
      u0_q        <= u0_d;
      u1_q        <= u1_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_q.ok;
  assign lease_number_o  = out_q.lease;
  assign where_now_o     = out_q.now;
  assign where_before_o  = out_q.prior;
  assign bytes_moved_o   = out_q.moved;
  assign out_of_memory_o = out_q.oom;
  assign pool0_bytes_o   = out_q.p0;
  assign pool1_bytes_o   = out_q.p1;
  assign host_bytes_o    = out_q.host;
  assign lease_count_o   = out_q.count;
  assign balanced_o      = out_q.balanced;

  // The lease count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TABLE_DEPTH)
    else $error("lease count beyond table depth");

  // A new result only appears after the final step of an action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result presented outside the final step");

  // A failed action reports no lease and no moved bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.ok) |-> (out_q.lease == 32'd0 && out_q.moved == 48'd0))
    else $error("failed action reports a lease");

  // A location is never the unused fourth code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.now != 2'd3 && out_q.prior != 2'd3))
    else $error("invalid location in result");

endmodule
